>>> rtl/i2c_master_command_and_read_defines.svh
// ----------------------------------------------------------------------------
// I2C master command and read: assertion macros
// Shared helpers for concurrent checks clocked on i_clk; one is held off in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_COMMAND_AND_READ_DEFINES_SVH
`define I2C_MASTER_COMMAND_AND_READ_DEFINES_SVH

// Check that is skipped while the synchronous reset is asserted.
`define I2CMCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also runs during reset.
`define I2CMCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/i2cmcr_pkg.sv
// ----------------------------------------------------------------------------
// I2C master command and read: package
// Sequence step codes, field widths and the structs shared by the modules.
// ----------------------------------------------------------------------------
package i2cmcr_pkg;

    // Widths of the step code and counters.
    localparam int STEP_W  = 4;
    localparam int BIT_W   = 4;
    localparam int BYTES_W = 3;
    localparam int EFF_W   = 5;

    // Default read length limit.
    localparam int MAX_READ_BYTES_DEF = 4;

    // Bits per byte on the bus.
    localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

    // Sequence step codes.
    localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] ST_START   = 4'd1;
    localparam logic [STEP_W-1:0] ST_ADDR    = 4'd2;
    localparam logic [STEP_W-1:0] ST_CMD     = 4'd3;
    localparam logic [STEP_W-1:0] ST_RDATA   = 4'd4;
    localparam logic [STEP_W-1:0] ST_STOP    = 4'd5;
    localparam logic [STEP_W-1:0] ST_STOPEND = 4'd6;

    // Request kinds carried with each tick.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
    localparam logic [1:0] CFG_READ_COUNT = 2'd1;

    // Configuration handed to the sequencer.
    typedef struct packed {
        logic [7:0]         dev_addr;
        logic [BYTES_W-1:0] read_count;
    } t_cfg;

    // Line levels and received byte for one tick.
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       byte_last;
    } t_result;

endpackage

>>> rtl/i2cmcr_core.sv
// ----------------------------------------------------------------------------
// I2C master command and read: bit sequencer
// Holds the transaction state and works out one tick's line levels.
// ----------------------------------------------------------------------------
`include "i2c_master_command_and_read_defines.svh"

module i2cmcr_core
    import i2cmcr_pkg::*;
#(
    parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_cmd,
    input  logic       i_sda,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    logic [STEP_W-1:0]  r_step,   n_step;
    logic               r_phase,  n_phase;
    logic [BIT_W-1:0]   r_bit,    n_bit;
    logic [7:0]         r_shift,  n_shift;
    logic [BYTES_W-1:0] r_bytes,  n_bytes;
    logic               r_is_read, n_is_read;
    logic [7:0]         r_held,   n_held;

    logic [EFF_W-1:0] eff_count;
    logic             last_byte;
    logic             ph;
    logic             is_req;

    // Read length clamped to the range one to MAX_READ_BYTES.
    always_comb begin
        if (i_cfg.read_count == '0) begin
            eff_count = EFF_W'(1);
        end else if (EFF_W'(i_cfg.read_count) > EFF_W'(MAX_READ_BYTES)) begin
            eff_count = EFF_W'(MAX_READ_BYTES);
        end else begin
            eff_count = EFF_W'(i_cfg.read_count);
        end
    end

    assign is_req = (r_step == ST_IDLE) && (i_mode == MODE_WRITE || i_mode == MODE_READ);

    // Next state and line levels for this tick.
    always_comb begin
        n_step    = r_step;
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_bytes   = r_bytes;
        n_is_read = r_is_read;
        n_held    = r_held;
        ph        = r_phase;
        o_res     = '0;
        o_res.scl      = 1'b1;
        o_res.sda_out  = 1'b1;
        o_res.busy_res = 1'b1;

        // A request from idle loads the address byte and starts the sequence.
        if (is_req) begin
            n_is_read = (i_mode == MODE_READ);
            n_held    = i_cmd;
            n_shift   = i_cfg.dev_addr + {7'd0, n_is_read};
            n_step    = ST_START;
            n_bit     = '0;
            n_bytes   = '0;
            ph        = 1'b0;
        end

        last_byte = (EFF_W'(n_bytes) + EFF_W'(1)) >= eff_count;

        case (n_step)
            ST_IDLE: begin
                o_res.busy_res = 1'b0;
            end
            ST_START: begin
                o_res.sda_out = ~ph;
                if (ph) begin
                    n_step = ST_ADDR;
                    n_bit  = '0;
                end
            end
            ST_ADDR, ST_CMD: begin
                o_res.scl = ph;
                if (n_bit < BITS_PER_BYTE) begin
                    o_res.sda_out = n_shift[7];
                    if (ph) begin
                        n_shift = {n_shift[6:0], 1'b0};
                        n_bit   = n_bit + BIT_W'(1);
                    end
                end else begin
                    // Slave acknowledge slot: clocked, not checked.
                    if (ph) begin
                        n_bit = '0;
                        if (n_step == ST_ADDR) begin
                            if (n_is_read) begin
                                n_step  = ST_RDATA;
                                n_shift = '0;
                                n_bytes = '0;
                            end else begin
                                n_step  = ST_CMD;
                                n_shift = n_held;
                            end
                        end else begin
                            n_step = ST_STOP;
                        end
                    end
                end
            end
            ST_RDATA: begin
                o_res.scl = ph;
                if (n_bit < BITS_PER_BYTE) begin
                    if (ph) begin
                        n_shift = {n_shift[6:0], i_sda};
                        n_bit   = n_bit + BIT_W'(1);
                        if (n_bit == BITS_PER_BYTE) begin
                            o_res.byte_valid = 1'b1;
                            o_res.byte_value = n_shift;
                            o_res.byte_last  = last_byte;
                        end
                    end
                end else begin
                    // Master ACK on all bytes but the last, NAK on the last.
                    o_res.sda_out = last_byte;
                    if (ph) begin
                        n_bytes = n_bytes + BYTES_W'(1);
                        n_bit   = '0;
                        n_shift = '0;
                        if (last_byte) begin
                            n_step = ST_STOP;
                        end
                    end
                end
            end
            ST_STOP: begin
                o_res.scl     = ph;
                o_res.sda_out = 1'b0;
                if (ph) begin
                    n_step = ST_STOPEND;
                end
            end
            ST_STOPEND: begin
                n_step = ST_IDLE;
            end
            default: begin
                n_step         = ST_IDLE;
                o_res.busy_res = 1'b0;
            end
        endcase

        // The half-bit phase toggles only while a transaction continues.
        if (o_res.busy_res && n_step != ST_IDLE) begin
            n_phase = ~ph;
        end else begin
            n_phase = 1'b0;
        end
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_phase   <= 1'b0;
            r_bit     <= '0;
            r_shift   <= '0;
            r_bytes   <= '0;
            r_is_read <= 1'b0;
            r_held    <= '0;
        end else if (i_step) begin
            r_step    <= n_step;
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_bytes   <= n_bytes;
            r_is_read <= n_is_read;
            r_held    <= n_held;
        end
    end

    // A received byte is only reported on a clock-high tick of the read phase.
    `I2CMCR_ASSERT(a_byte_in_read,
        (i_step && o_res.byte_valid) |-> (r_step == ST_RDATA && r_phase),
        "byte reported outside read phase")
    // The bit counter never passes the acknowledge slot.
    `I2CMCR_ASSERT(a_bit_range, r_bit <= BITS_PER_BYTE, "bit counter out of range")
    // Idle always restarts at phase zero.
    `I2CMCR_ASSERT(a_idle_phase, (r_step == ST_IDLE) |-> !r_phase, "phase set while idle")
    // The tick after the stop's release returns to idle.
    `I2CMCR_ASSERT(a_stop_end,
        (i_step && r_step == ST_STOPEND) |=> (r_step == ST_IDLE),
        "stop end did not return to idle")

endmodule

>>> rtl/i2c_master_command_and_read.sv
// ----------------------------------------------------------------------------
// I2C master command and read: top level
// Bit-level I2C master stepped by half-bit ticks, with a result register.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Words carried
//  s_axis   | in        | one half-bit tick: request kind, command byte, SDA level
//  m_axis   | out       | one result per tick: SCL, SDA, busy, received byte
//  cfg      | in        | register writes: device address, read length
//
//  A tick is accepted every cycle while the result register is free or drained.
//  Each tick's result is captured in the result register when the tick is accepted.
//  Sustained rate is one tick per cycle; only the output handshake stalls it.
//  Reset is synchronous: sequencer idle, output empty, config registers at defaults.
// ----------------------------------------------------------------------------
module i2c_master_command_and_read
    import i2cmcr_pkg::*;
#(
    parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] command_byte, [8] sda_in, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] scl, [1] sda_out, [2] busy_res,
                                        // [10:3] byte_value, rest zero
    output logic [0:0]  m_axis_tuser,   // [0] byte_valid
    output logic        m_axis_tlast,   // byte_last

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    t_cfg    r_cfg;
    logic    in_word;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_word       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr   <= 8'd70;
            r_cfg.read_count <= BYTES_W'(2);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEV_ADDR:   r_cfg.dev_addr   <= i_cfg_data;
                CFG_READ_COUNT: r_cfg.read_count <= i_cfg_data[BYTES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    i2cmcr_core #(
        .MAX_READ_BYTES (MAX_READ_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_word),
        .i_mode  (s_axis_tuser),
        .i_cmd   (s_axis_tdata[7:0]),
        .i_sda   (s_axis_tdata[8]),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    // Result register: loads on every accepted tick, drains on the output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_word) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_word) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.byte_value, r_out.busy_res, r_out.sda_out, r_out.scl};
    assign m_axis_tuser  = r_out.byte_valid;
    assign m_axis_tlast  = r_out.byte_last;

endmodule
